>>> rtl/mlpq_pkg.sv
// Shared types and constants for the multilevel priority FIFO.
// No dependencies; every other rtl file takes names from here by scope.
`timescale 1ns / 1ps

package mlpq_pkg;

  // Queue geometry
  localparam int MAX_LEVELS  = 8;
  localparam int LEVEL_DEPTH = 16;

  localparam int LVL_W  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int PTR_W  = $clog2(LEVEL_DEPTH);
  localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int ADDR_W = $clog2(MAX_LEVELS * LEVEL_DEPTH);

  // Fixed field widths
  localparam int VAL_W  = 32;
  localparam int PRIO_W = 8;
  localparam int POUT_W = 3;
  localparam int CFG_W  = 4;

  localparam logic [CFG_W-1:0] LEVELS_RESET = 4'd8;

  // Command codes
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_PRIO = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;  // capture the incoming item
    logic exec;  // run the captured item against the level state
  } ctl_t;

endpackage

>>> rtl/mlpq_ctrl.sv
// Controller state machine for the multilevel priority FIFO.
// Depends on mlpq_pkg (state_t, ctl_t).
`timescale 1ns / 1ps

module mlpq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output logic          done,
  output mlpq_pkg::ctl_t ctl
);

  mlpq_pkg::state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mlpq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    ctl.load   = 1'b0;
    ctl.exec   = 1'b0;
    busy       = 1'b0;
    done       = 1'b0;
    unique case (state)
      mlpq_pkg::S_IDLE: begin
        if (start) begin
          ctl.load   = 1'b1;
          state_next = mlpq_pkg::S_EXEC;
        end
      end
      mlpq_pkg::S_EXEC: begin
        busy       = 1'b1;
        ctl.exec   = 1'b1;
        state_next = mlpq_pkg::S_RESP;
      end
      mlpq_pkg::S_RESP: begin
        // result goes out while the next item may already be taken
        done = 1'b1;
        if (start) begin
          ctl.load   = 1'b1;
          state_next = mlpq_pkg::S_EXEC;
        end else begin
          state_next = mlpq_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = mlpq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/mlpq_datapath.sv
// Datapath: level heads and counts, item store, level scan and result registers.
// Depends on mlpq_pkg (geometry constants, status_t, ctl_t).
`timescale 1ns / 1ps

module mlpq_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  mlpq_pkg::ctl_t                      ctl,
  input  logic                                cfg_write,
  input  logic [mlpq_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                command,
  input  logic signed [mlpq_pkg::VAL_W-1:0]   value_in,
  input  logic [mlpq_pkg::PRIO_W-1:0]         priority_in,
  output logic [1:0]                          status,
  output logic signed [mlpq_pkg::VAL_W-1:0]   value_out,
  output logic [mlpq_pkg::POUT_W-1:0]         priority_out
);

  localparam int NUM_ENTRIES = mlpq_pkg::MAX_LEVELS * mlpq_pkg::LEVEL_DEPTH;

  // Captured item
  logic                              cmd;
  logic [mlpq_pkg::VAL_W-1:0]        val;
  logic [mlpq_pkg::PRIO_W-1:0]       prio;
  logic [mlpq_pkg::CFG_W-1:0]        levels_in_use;

  // Per-level ring state
  logic [mlpq_pkg::PTR_W-1:0]        level_head  [mlpq_pkg::MAX_LEVELS];
  logic [mlpq_pkg::CNT_W-1:0]        level_count [mlpq_pkg::MAX_LEVELS];

  // Item store
  logic [mlpq_pkg::VAL_W-1:0]        item_store [NUM_ENTRIES];
  logic [mlpq_pkg::VAL_W-1:0]        rd_data;

  // Result registers
  mlpq_pkg::status_t                 res_status;
  logic [mlpq_pkg::POUT_W-1:0]       res_prio;
  logic                              res_ok;

  // Combinational decision
  logic                              found;
  logic [mlpq_pkg::LVL_W-1:0]        found_lvl;
  logic [mlpq_pkg::LVL_W-1:0]        idx;
  logic [mlpq_pkg::PTR_W-1:0]        cur_head;
  logic [mlpq_pkg::CNT_W-1:0]        cur_cnt;
  logic [mlpq_pkg::SUM_W-1:0]        tail_sum;
  logic [mlpq_pkg::PTR_W-1:0]        tail_slot;
  logic [mlpq_pkg::PTR_W-1:0]        slot;
  logic [mlpq_pkg::PTR_W-1:0]        head_inc;
  logic [mlpq_pkg::ADDR_W-1:0]       addr;
  logic                              bad_prio;
  logic                              enq_ok;
  logic                              deq_ok;
  mlpq_pkg::status_t                 st;

  // Item capture
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd  <= command;
      val  <= value_in;
      prio <= priority_in;
    end
  end

  // Level count register
  always_ff @(posedge clk) begin
    if (rst) begin
      levels_in_use <= mlpq_pkg::LEVELS_RESET;
    end else if (cfg_write) begin
      levels_in_use <= cfg_data;
    end
  end

  // Priority encoder over non-empty levels, lowest level wins
  always_comb begin
    found     = 1'b0;
    found_lvl = '0;
    for (int i = mlpq_pkg::MAX_LEVELS - 1; i >= 0; i--) begin
      if (level_count[i] != '0) begin
        found     = 1'b1;
        found_lvl = mlpq_pkg::LVL_W'(i);
      end
    end
  end

  // Slot and status for the captured item
  always_comb begin
    idx      = (cmd == mlpq_pkg::CMD_DEQ) ? found_lvl : prio[mlpq_pkg::LVL_W-1:0];
    cur_head = level_head[idx];
    cur_cnt  = level_count[idx];

    // tail slot = (head + count) mod depth, sum stays below twice the depth
    tail_sum = mlpq_pkg::SUM_W'(cur_head) + mlpq_pkg::SUM_W'(cur_cnt);
    if (tail_sum >= mlpq_pkg::SUM_W'(mlpq_pkg::LEVEL_DEPTH)) begin
      tail_slot = mlpq_pkg::PTR_W'(tail_sum - mlpq_pkg::SUM_W'(mlpq_pkg::LEVEL_DEPTH));
    end else begin
      tail_slot = mlpq_pkg::PTR_W'(tail_sum);
    end

    if (cur_head == mlpq_pkg::PTR_W'(mlpq_pkg::LEVEL_DEPTH - 1)) begin
      head_inc = '0;
    end else begin
      head_inc = cur_head + 1'b1;
    end

    slot = (cmd == mlpq_pkg::CMD_DEQ) ? cur_head : tail_slot;
    addr = mlpq_pkg::ADDR_W'(idx) * mlpq_pkg::ADDR_W'(mlpq_pkg::LEVEL_DEPTH)
         + mlpq_pkg::ADDR_W'(slot);

    bad_prio = (prio >= mlpq_pkg::PRIO_W'(levels_in_use))
            || (prio >= mlpq_pkg::PRIO_W'(mlpq_pkg::MAX_LEVELS));

    enq_ok = 1'b0;
    deq_ok = 1'b0;
    st     = mlpq_pkg::ST_OK;
    if (cmd == mlpq_pkg::CMD_ENQ) begin
      if (bad_prio) begin
        st = mlpq_pkg::ST_BAD_PRIO;
      end else if (cur_cnt >= mlpq_pkg::CNT_W'(mlpq_pkg::LEVEL_DEPTH)) begin
        st = mlpq_pkg::ST_FULL;
      end else begin
        enq_ok = 1'b1;
      end
    end else begin
      if (!found) begin
        st = mlpq_pkg::ST_EMPTY;
      end else begin
        deq_ok = 1'b1;
      end
    end
  end

  // Head and count update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mlpq_pkg::MAX_LEVELS; i++) begin
        level_head[i]  <= '0;
        level_count[i] <= '0;
      end
    end else if (ctl.exec) begin
      if (enq_ok) begin
        level_count[idx] <= cur_cnt + 1'b1;
      end else if (deq_ok) begin
        level_head[idx]  <= head_inc;
        level_count[idx] <= cur_cnt - 1'b1;
      end
    end
  end

  // Item store: one write or one registered read per item
  always_ff @(posedge clk) begin
    if (ctl.exec && enq_ok) begin
      item_store[addr] <= val;
    end
    if (ctl.exec && deq_ok) begin
      rd_data <= item_store[addr];
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      res_status <= st;
      res_prio   <= mlpq_pkg::POUT_W'(found_lvl);
      res_ok     <= deq_ok;
    end
  end

  assign status       = res_status;
  assign value_out    = res_ok ? rd_data : '0;
  assign priority_out = res_ok ? res_prio : '0;

endmodule

>>> rtl/multilevel_priority_fifo.sv
// Multilevel priority FIFO: one ring per level in a shared item store, level 0 first.
// After the accepting edge the controller passes through S_EXEC; done is raised in S_RESP.
// A new item can be taken in S_RESP while the last result goes out; busy is held in S_EXEC.
// Reset clears every level's head and count and sets levels_in_use to 8; the store is
// not cleared. The receiver cannot stall: each result shows for exactly one cycle.
// Depends on mlpq_pkg, mlpq_ctrl and mlpq_datapath.
`timescale 1ns / 1ps

module multilevel_priority_fifo (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                cfg_write,
  input  logic [mlpq_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                command,
  input  logic signed [mlpq_pkg::VAL_W-1:0]   value_in,
  input  logic [mlpq_pkg::PRIO_W-1:0]         priority_in,
  output logic                                done,
  output logic [1:0]                          status,
  output logic signed [mlpq_pkg::VAL_W-1:0]   value_out,
  output logic [mlpq_pkg::POUT_W-1:0]         priority_out
);

  mlpq_pkg::ctl_t ctl;

  // Sequencing
  mlpq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .ctl   (ctl)
  );

  // Queue state and results
  mlpq_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .command      (command),
    .value_in     (value_in),
    .priority_in  (priority_in),
    .status       (status),
    .value_out    (value_out),
    .priority_out (priority_out)
  );

endmodule

>>> verif/multilevel_priority_fifo_tb.sv
// Self-checking testbench for multilevel_priority_fifo: directed and random queue commands
// are checked against a per-level FIFO tracker. Depends on mlpq_pkg and the block's rtl.
`timescale 1ns / 1ps

module multilevel_priority_fifo_tb;
  import mlpq_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_PHASES  = 8;

  // One expected result of a queue command
  typedef struct {
    status_t                 st;
    logic signed [VAL_W-1:0] val;
    logic [POUT_W-1:0]       lvl;
  } outcome_t;

  // Tracks every level's contents and the results still owed by the block
  class prio_queue_tracker;
    int unsigned             levels_limit;
    logic signed [VAL_W-1:0] slots [MAX_LEVELS][LEVEL_DEPTH];
    int unsigned             head [MAX_LEVELS];
    int unsigned             fill [MAX_LEVELS];
    outcome_t                owed[$];
    int unsigned             mismatch_count;

    function new();
      levels_limit   = int'(LEVELS_RESET);
      mismatch_count = 0;
      foreach (head[i]) begin
        head[i] = 0;
        fill[i] = 0;
      end
    endfunction

    // Levels above MAX_LEVELS saturate
    function void set_levels(logic [CFG_W-1:0] v);
      levels_limit = (int'(v) > MAX_LEVELS) ? MAX_LEVELS : int'(v);
    endfunction

    function void accept_command(logic cmd, logic signed [VAL_W-1:0] val,
                                 logic [PRIO_W-1:0] prio);
      outcome_t o;
      int       lvl;
      o.st  = ST_OK;
      o.val = '0;
      o.lvl = '0;
      if (cmd == CMD_ENQ) begin
        if (prio >= levels_limit) begin
          o.st = ST_BAD_PRIO;
        end else if (fill[prio] >= LEVEL_DEPTH) begin
          o.st = ST_FULL;
        end else begin
          slots[prio][(head[prio] + fill[prio]) % LEVEL_DEPTH] = val;
          fill[prio]++;
        end
      end else begin
        // lowest-numbered non-empty level wins, whatever levels_limit is now
        lvl = -1;
        for (int i = MAX_LEVELS - 1; i >= 0; i--) begin
          if (fill[i] != 0) lvl = i;
        end
        if (lvl < 0) begin
          o.st = ST_EMPTY;
        end else begin
          o.val     = slots[lvl][head[lvl]];
          o.lvl     = lvl[POUT_W-1:0];
          head[lvl] = (head[lvl] + 1) % LEVEL_DEPTH;
          fill[lvl]--;
        end
      end
      owed.insert(owed.size(), o);
    endfunction

    function void report(string field, longint exp_v, longint act_v);
      mismatch_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_v, act_v);
    endfunction

    function void compare_result(logic [1:0] st, logic signed [VAL_W-1:0] val,
                                 logic [POUT_W-1:0] lvl);
      outcome_t e;
      if (owed.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none, actual status %0d value %h level %0d",
                 $time, st, val, lvl);
        return;
      end
      e = owed.pop_front();
      if (st !== e.st) report("status", e.st, st);
      if (val !== e.val) report("value_out", e.val, val);
      if (lvl !== e.lvl) report("priority_out", e.lvl, lvl);
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic                    cfg_write = 1'b0;
  logic [CFG_W-1:0]        cfg_data = '0;
  logic                    command = CMD_ENQ;
  logic signed [VAL_W-1:0] value_in = '0;
  logic [PRIO_W-1:0]       priority_in = '0;
  logic                    done;
  logic [1:0]              status;
  logic signed [VAL_W-1:0] value_out;
  logic [POUT_W-1:0]       priority_out;

  prio_queue_tracker tracker = new();
  int                idle_pct = 0;
  int unsigned       cycles = 0;

  // Per phase: levels_in_use, sender idle percentage, random items
  int phase_levels [NUM_PHASES] = '{8, 15, 0, 1, 3, 8, 5, 2};
  int phase_idle   [NUM_PHASES] = '{0, 82, 7, 0, 82, 7, 0, 82};
  int phase_items  [NUM_PHASES] = '{280, 240, 100, 240, 260, 280, 250, 230};

  multilevel_priority_fifo DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .command      (command),
    .value_in     (value_in),
    .priority_in  (priority_in),
    .done         (done),
    .status       (status),
    .value_out    (value_out),
    .priority_out (priority_out)
  );

  always #2 clk = ~clk;

  // Results first: a result at this edge always belongs to an older item
  always @(posedge clk) begin
    if (!rst) begin
      if (done) tracker.compare_result(status, value_out, priority_out);
      if (start && !busy) tracker.accept_command(command, value_in, priority_in);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Present one item, with random idle cycles ahead of it, and hold it until accepted
  task automatic issue(input logic cmd, input logic signed [VAL_W-1:0] val,
                       input logic [PRIO_W-1:0] prio);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    command     <= cmd;
    value_in    <= val;
    priority_in <= prio;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Stop issuing and wait for every owed result
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (tracker.owed.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_levels(input logic [CFG_W-1:0] v);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    tracker.set_levels(v);
  endtask

  // Random command; enq_pct biases toward filling or draining the levels
  task automatic random_item(input int enq_pct);
    logic                    cmd;
    logic signed [VAL_W-1:0] val;
    logic [PRIO_W-1:0]       prio;
    int                      r;
    cmd = ($urandom_range(99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
    r = $urandom_range(99);
    if (r < 82)      prio = PRIO_W'($urandom_range(0, MAX_LEVELS - 1));
    else if (r < 96) prio = PRIO_W'($urandom_range(0, 255));
    else             prio = (r[0]) ? 8'd255 : 8'(MAX_LEVELS);
    r = $urandom_range(99);
    case (r % 10)
      0: begin
        val = (r < 50) ? 32'sh7fff_ffff : 32'sh8000_0000;
      end
      1: begin
        val = (r < 50) ? 32'sd0 : -32'sd1;
      end
      default: begin
        val = $urandom;
      end
    endcase
    issue(cmd, val, prio);
  endtask

  initial begin
    int bias;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty queue, value extremes, bad priorities, order across levels
    issue(CMD_DEQ, 32'sd0, 8'd0);
    issue(CMD_ENQ, 32'sh7fff_ffff, 8'd0);
    issue(CMD_ENQ, 32'sh8000_0000, 8'd7);
    issue(CMD_ENQ, 32'sd5, 8'(MAX_LEVELS));
    issue(CMD_ENQ, 32'sd6, 8'd255);
    issue(CMD_ENQ, -32'sd1, 8'd3);
    issue(CMD_DEQ, $urandom, PRIO_W'($urandom));
    issue(CMD_DEQ, $urandom, PRIO_W'($urandom));
    issue(CMD_DEQ, $urandom, PRIO_W'($urandom));
    // Fill one level past its depth
    for (int i = 0; i <= LEVEL_DEPTH; i++) issue(CMD_ENQ, $urandom, 8'd6);

    // Random phases, each under its own level limit and idling
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      write_levels(CFG_W'(phase_levels[p]));
      idle_pct = phase_idle[p];
      bias = 55;
      for (int n = 0; n < phase_items[p]; n++) begin
        if (n % 32 == 0) begin
          case ($urandom_range(2))
            0:       bias = 85;
            1:       bias = 20;
            default: bias = 55;
          endcase
        end
        random_item(bias);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (tracker.mismatch_count == 0 && tracker.owed.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
